FILE: hw/rtl/ljpf_pkg.sv
// ljpf_pkg: widths, configuration register indexes, side-band structs and the
// force clipping function of the Lennard-Jones pair force pipeline.
// No dependencies; imported by every module of the block.
package ljpf_pkg;

  localparam int COORD_W    = 32;                // Q16.16 coordinate
  localparam int DIFF_W     = COORD_W + 1;       // signed coordinate difference
  localparam int RAD_W      = 2 * DIFF_W;        // squared distance, even width
  localparam int ROOT_W     = DIFF_W;            // distance r
  localparam int CUTOFF_W   = 33;
  localparam int SIGMA_W    = 32;
  localparam int SCALE_W    = 48;
  localparam int WORD_W     = 64;                // Q32.32 word
  localparam int FRAC_W     = 32;                // Q32.32 fraction bits
  localparam int COS_W      = 33;                // direction cosine, up to 2^32
  localparam int FORCE_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SCALE_W;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 33'h1_FFFF_FFFF;
  localparam logic [SIGMA_W-1:0]  SIGMA_RESET  = 32'd65536;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 48'd93224512287;

  localparam logic [FORCE_W-1:0] FORCE_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [FORCE_W-1:0] FORCE_NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF = 2'd0,
    CFG_SIGMA  = 2'd1,
    CFG_SCALE  = 2'd2
  } cfg_index_t;

  // per-pair flags settled once r is known
  typedef struct packed {
    logic coincident;
    logic outside;
    logic neg_x;
    logic neg_y;
  } pair_flags_t;

  // travels alongside the power chain s^2 .. s^13
  typedef struct packed {
    pair_flags_t         fl;
    logic [WORD_W-1:0]   s;
    logic [COS_W-1:0]    cx;
    logic [COS_W-1:0]    cy;
    logic [WORD_W-1:0]   s7;
    logic                h7;
    logic                h13;
  } power_side_t;

  // travels alongside the magnitude product
  typedef struct packed {
    pair_flags_t         fl;
    logic [COS_W-1:0]    cx;
    logic [COS_W-1:0]    cy;
    logic                t_neg;
    logic                t_huge;
  } mag_side_t;

  // travels alongside the component products
  typedef struct packed {
    pair_flags_t fl;
    logic        t_neg;
    logic        m_unb;
    logic        cx_zero;
    logic        cy_zero;
  } comp_side_t;

  typedef struct packed {
    logic               sat;
    logic [FORCE_W-1:0] val;
  } comp_out_t;

  // sign, clip and zero handling of one force component
  function automatic comp_out_t comp_force(logic [WORD_W-1:0] mag, logic ovf, logic unb,
                                           logic neg, logic czero);
    comp_out_t          o;
    logic [FORCE_W-1:0] limit;
    logic [FORCE_W-1:0] m;
    limit = neg ? FORCE_NEG_LIMIT : FORCE_POS_LIMIT;
    o.sat = 1'b0;
    m     = mag;
    if (czero) begin
      m = '0;
    end else if (unb || ovf || (mag > limit)) begin
      o.sat = 1'b1;
      m     = limit;
    end
    o.val = neg ? ('0 - m) : m;
    return o;
  endfunction

endpackage

FILE: hw/rtl/ljpf_mulq.sv
// ljpf_mulq: two-stage Q32.32 multiplier, floor(a*b / 2^32) with overflow flag,
// one or more lanes in lockstep plus a side-band word. Uses ljpf_pkg.
// Stage one forms 32x32 partial products, stage two sums and checks range.
module ljpf_mulq #(
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [LANES-1:0][ljpf_pkg::WORD_W-1:0] a,
  input  logic [LANES-1:0][ljpf_pkg::WORD_W-1:0] b,
  input  logic [SIDE_W-1:0]                      side_in,
  output logic                                   out_valid,
  output logic [LANES-1:0][ljpf_pkg::WORD_W-1:0] res,
  output logic [LANES-1:0]                       ovf,
  output logic [SIDE_W-1:0]                      side_out
);
  import ljpf_pkg::*;

  localparam int HALF_W = WORD_W / 2;
  localparam int PROD_W = 2 * WORD_W;

  logic                                pp_valid;
  logic [LANES-1:0][3:0][WORD_W-1:0]   pp;
  logic [SIDE_W-1:0]                   pp_side;
  logic [LANES-1:0][PROD_W-1:0]        full;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      pp_valid  <= in_valid;
      out_valid <= pp_valid;
    end
  end

  // partial products: ll, lh, hl, hh
  always_ff @(posedge clk) begin
    if (en) begin
      pp_side  <= side_in;
      side_out <= pp_side;
      for (int l = 0; l < LANES; l++) begin
        pp[l][0] <= a[l][HALF_W-1:0]      * b[l][HALF_W-1:0];
        pp[l][1] <= a[l][HALF_W-1:0]      * b[l][WORD_W-1:HALF_W];
        pp[l][2] <= a[l][WORD_W-1:HALF_W] * b[l][HALF_W-1:0];
        pp[l][3] <= a[l][WORD_W-1:HALF_W] * b[l][WORD_W-1:HALF_W];
      end
    end
  end

  // partial product sum
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      full[l] = {pp[l][3], {WORD_W{1'b0}}}
              + {{HALF_W{1'b0}}, pp[l][1], {HALF_W{1'b0}}}
              + {{HALF_W{1'b0}}, pp[l][2], {HALF_W{1'b0}}}
              + {{WORD_W{1'b0}}, pp[l][0]};
    end
  end

  // scale back to Q32.32, all ones when out of range
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        ovf[l] <= |full[l][PROD_W-1:WORD_W+FRAC_W];
        res[l] <= (|full[l][PROD_W-1:WORD_W+FRAC_W]) ? '1 : full[l][WORD_W+FRAC_W-1:FRAC_W];
      end
    end
  end

endmodule

FILE: hw/rtl/ljpf_sqrt.sv
// ljpf_sqrt: pipelined integer square root, one root bit per stage, with a
// side-band word carried alongside. Uses ljpf_pkg for the widths.
module ljpf_sqrt #(
  parameter int SIDE_W = 66
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ljpf_pkg::RAD_W-1:0]  rad,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [ljpf_pkg::ROOT_W-1:0] root,
  output logic [SIDE_W-1:0]           side_out
);
  import ljpf_pkg::*;

  localparam int STAGES = ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int TRY_W  = REM_W + 2;

  logic                vld    [STAGES];
  logic [RAD_W-1:0]    rad_q  [STAGES];
  logic [REM_W-1:0]    rem_q  [STAGES];
  logic [ROOT_W-1:0]   root_q [STAGES];
  logic [SIDE_W-1:0]   side_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic              p_vld;
    logic [RAD_W-1:0]  p_rad;
    logic [REM_W-1:0]  p_rem;
    logic [ROOT_W-1:0] p_root;
    logic [SIDE_W-1:0] p_side;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  sub;
    logic [TRY_W-1:0]  diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rad  = rad;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_side = side_in;
    end else begin : g_next
      assign p_vld  = vld[i-1];
      assign p_rad  = rad_q[i-1];
      assign p_rem  = rem_q[i-1];
      assign p_root = root_q[i-1];
      assign p_side = side_q[i-1];
    end

    // try root bit: remainder*4 + next pair against root*4 + 1
    assign trial = {p_rem, p_rad[RAD_W-1 -: 2]};
    assign sub   = {{(TRY_W-ROOT_W-2){1'b0}}, p_root, 2'b01};
    assign ge    = trial >= sub;
    assign diff  = trial - sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i]  <= p_rad << 2;
        rem_q[i]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        root_q[i] <= {p_root[ROOT_W-2:0], ge};
        side_q[i] <= p_side;
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign root      = root_q[STAGES-1];
  assign side_out  = side_q[STAGES-1];

endmodule

FILE: hw/rtl/ljpf_div.sv
// ljpf_div: pipelined restoring divider, one quotient bit per stage, several
// numerators over one common divisor. Uses ljpf_pkg; side-band word carried along.
module ljpf_div #(
  parameter int LANES  = 3,
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 33,
  parameter int SIDE_W = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] num,
  input  logic [DEN_W-1:0]            den,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [LANES-1:0][NUM_W-1:0] quo,
  output logic [SIDE_W-1:0]           side_out
);
  import ljpf_pkg::*;

  localparam int STAGES = NUM_W;

  logic                        vld    [STAGES];
  logic [LANES-1:0][DEN_W-1:0] rem_q  [STAGES];
  logic [LANES-1:0][NUM_W-1:0] nq_q   [STAGES];
  logic [DEN_W-1:0]            den_q  [STAGES];
  logic [SIDE_W-1:0]           side_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                        p_vld;
    logic [LANES-1:0][DEN_W-1:0] p_rem;
    logic [LANES-1:0][NUM_W-1:0] p_nq;
    logic [DEN_W-1:0]            p_den;
    logic [SIDE_W-1:0]           p_side;
    logic [LANES-1:0][DEN_W-1:0] n_rem;
    logic [LANES-1:0][NUM_W-1:0] n_nq;

    if (i == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_nq   = num;
      assign p_den  = den;
      assign p_side = side_in;
    end else begin : g_next
      assign p_vld  = vld[i-1];
      assign p_rem  = rem_q[i-1];
      assign p_nq   = nq_q[i-1];
      assign p_den  = den_q[i-1];
      assign p_side = side_q[i-1];
    end

    // shift in the next numerator bit, subtract where it fits
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] t;
      logic [DEN_W:0] d;
      logic           ge;
      assign t  = {p_rem[l], p_nq[l][NUM_W-1]};
      assign ge = t >= {1'b0, p_den};
      assign d  = t - {1'b0, p_den};
      assign n_rem[l] = ge ? d[DEN_W-1:0] : t[DEN_W-1:0];
      assign n_nq[l]  = {p_nq[l][NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= n_rem;
        nq_q[i]   <= n_nq;
        den_q[i]  <= p_den;
        side_q[i] <= p_side;
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign quo       = nq_q[STAGES-1];
  assign side_out  = side_q[STAGES-1];

endmodule

FILE: hw/rtl/lennard_jones_pair_force.sv
// lennard_jones_pair_force: top level of the 2D Lennard-Jones 12-6 pair force
// pipeline. Uses ljpf_pkg, ljpf_sqrt, ljpf_div and ljpf_mulq.
//
//   channel  | dir | payload
//   ---------+-----+-------------------------------------------------------
//   s_axis   | in  | tdata: first_x, first_y, second_x, second_y
//   m_axis   | out | tdata: force_x, force_y; tuser: saturated, coincident
//   cfg      | in  | cutoff_radius, sigma_length, force_scale (write only)
//
// One pair enters per cycle while s_tready is high; each pair passes through the
// 33-stage square root, the 64-stage divider for sigma/r and the direction
// cosines, and seven two-stage 64-bit multiplies. A stall at the output fills a
// one-entry skid stage; the whole pipeline then holds until the skid drains.
// Reset is synchronous, clears the valid bits and sets the configuration
// registers to their reset values.
module lennard_jones_pair_force (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [127:0]                    s_tdata,   // first_x, first_y, second_x, second_y
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [127:0]                    m_tdata,   // force_x, force_y
  output logic [1:0]                      m_tuser,   // saturated, coincident
  input  logic                            cfg_we,
  input  logic [ljpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ljpf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ljpf_pkg::*;

  logic                advance;
  logic [CUTOFF_W-1:0] cutoff_radius;
  logic [SIGMA_W-1:0]  sigma_length;
  logic [SCALE_W-1:0]  force_scale;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_radius <= CUTOFF_RESET;
      sigma_length  <= SIGMA_RESET;
      force_scale   <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CUTOFF: cutoff_radius <= cfg_data[CUTOFF_W-1:0];
        CFG_SIGMA:  sigma_length  <= cfg_data[SIGMA_W-1:0];
        CFG_SCALE:  force_scale   <= cfg_data[SCALE_W-1:0];
        default:    ;
      endcase
    end
  end

  assign s_tready = advance;

  // front stages: difference, squares, sum
  logic                     v0, v1, v2;
  logic signed [DIFF_W-1:0] dx0, dy0, dx1, dy1, dx2, dy2;
  logic [DIFF_W-1:0]        ax0, ay0;
  logic [2*COORD_W-1:0]     qx1, qy1;
  logic [RAD_W-1:0]         sum2;

  assign ax0 = dx0[DIFF_W-1] ? ('0 - dx0) : dx0;
  assign ay0 = dy0[DIFF_W-1] ? ('0 - dy0) : dy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v0 <= s_tvalid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dx0  <= {s_tdata[95], s_tdata[95:64]} - {s_tdata[31], s_tdata[31:0]};
      dy0  <= {s_tdata[127], s_tdata[127:96]} - {s_tdata[63], s_tdata[63:32]};
      qx1  <= ax0[COORD_W-1:0] * ax0[COORD_W-1:0];
      qy1  <= ay0[COORD_W-1:0] * ay0[COORD_W-1:0];
      dx1  <= dx0;
      dy1  <= dy0;
      sum2 <= {2'b00, qx1} + {2'b00, qy1};
      dx2  <= dx1;
      dy2  <= dy1;
    end
  end

  // distance r
  logic                     vr;
  logic [ROOT_W-1:0]        r;
  logic [2*DIFF_W-1:0]      r_side;
  logic signed [DIFF_W-1:0] dxr, dyr;
  logic [DIFF_W-1:0]        axr, ayr;
  pair_flags_t              fl_r;

  ljpf_sqrt #(.SIDE_W(2*DIFF_W)) u_sqrt (
    .clk(clk), .rst(rst), .en(advance),
    .in_valid(v2), .rad(sum2), .side_in({dx2, dy2}),
    .out_valid(vr), .root(r), .side_out(r_side)
  );

  assign dxr = r_side[2*DIFF_W-1:DIFF_W];
  assign dyr = r_side[DIFF_W-1:0];
  assign axr = dxr[DIFF_W-1] ? ('0 - dxr) : dxr;
  assign ayr = dyr[DIFF_W-1] ? ('0 - dyr) : dyr;
  assign fl_r.coincident = (r == '0);
  assign fl_r.outside    = (r >= cutoff_radius);
  assign fl_r.neg_x      = dxr[DIFF_W-1];
  assign fl_r.neg_y      = dyr[DIFF_W-1];

  // s = sigma/r and direction cosines |dx|/r, |dy|/r
  logic                         vd;
  logic [2:0][WORD_W-1:0]       div_num, div_quo;
  logic [$bits(pair_flags_t)-1:0] div_side;

  assign div_num[0] = {sigma_length, {FRAC_W{1'b0}}};
  assign div_num[1] = {axr[COORD_W-1:0], {FRAC_W{1'b0}}};
  assign div_num[2] = {ayr[COORD_W-1:0], {FRAC_W{1'b0}}};

  ljpf_div #(.LANES(3), .NUM_W(WORD_W), .DEN_W(ROOT_W), .SIDE_W($bits(pair_flags_t))) u_div (
    .clk(clk), .rst(rst), .en(advance),
    .in_valid(vr), .num(div_num), .den(r), .side_in(fl_r),
    .out_valid(vd), .quo(div_quo), .side_out(div_side)
  );

  // power chain
  power_side_t            ps1_in, ps1_out, ps2_in, ps2_out, ps3_in, ps3_out;
  power_side_t            ps4_in, ps4_out, ps5_in, ps5_out;
  logic                   vm1, vm2, vm3, vm4, vm5;
  logic [0:0][WORD_W-1:0] p1, p2, p3, p5;
  logic [0:0]             o1, o2, o3, o5;
  logic [1:0][WORD_W-1:0] p4, m4_a, m4_b;
  logic [1:0]             o4;

  always_comb begin
    ps1_in    = '0;
    ps1_in.fl = pair_flags_t'(div_side);
    ps1_in.s  = div_quo[0];
    ps1_in.cx = div_quo[1][COS_W-1:0];
    ps1_in.cy = div_quo[2][COS_W-1:0];
  end

  ljpf_mulq #(.LANES(1), .SIDE_W($bits(power_side_t))) u_s2 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vd),
    .a(div_quo[0]), .b(div_quo[0]), .side_in(ps1_in),
    .out_valid(vm1), .res(p1), .ovf(o1), .side_out(ps1_out)
  );

  always_comb begin
    ps2_in    = ps1_out;
    ps2_in.h7 = o1[0];
  end

  ljpf_mulq #(.LANES(1), .SIDE_W($bits(power_side_t))) u_s3 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vm1),
    .a(p1), .b(ps1_out.s), .side_in(ps2_in),
    .out_valid(vm2), .res(p2), .ovf(o2), .side_out(ps2_out)
  );

  always_comb begin
    ps3_in    = ps2_out;
    ps3_in.h7 = ps2_out.h7 | o2[0];
  end

  ljpf_mulq #(.LANES(1), .SIDE_W($bits(power_side_t))) u_s6 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vm2),
    .a(p2), .b(p2), .side_in(ps3_in),
    .out_valid(vm3), .res(p3), .ovf(o3), .side_out(ps3_out)
  );

  // s7 = s6*s and s12 = s6*s6 side by side
  always_comb begin
    ps4_in     = ps3_out;
    ps4_in.h7  = ps3_out.h7 | o3[0];
    ps4_in.h13 = ps3_out.h7 | o3[0];
    m4_a[0]    = p3[0];
    m4_b[0]    = ps3_out.s;
    m4_a[1]    = p3[0];
    m4_b[1]    = p3[0];
  end

  ljpf_mulq #(.LANES(2), .SIDE_W($bits(power_side_t))) u_s7_s12 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vm3),
    .a(m4_a), .b(m4_b), .side_in(ps4_in),
    .out_valid(vm4), .res(p4), .ovf(o4), .side_out(ps4_out)
  );

  always_comb begin
    ps5_in     = ps4_out;
    ps5_in.s7  = p4[0];
    ps5_in.h7  = ps4_out.h7 | o4[0];
    ps5_in.h13 = ps4_out.h13 | o4[1];
  end

  ljpf_mulq #(.LANES(1), .SIDE_W($bits(power_side_t))) u_s13 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vm4),
    .a(p4[1]), .b(ps4_out.s), .side_in(ps5_in),
    .out_valid(vm5), .res(p5), .ovf(o5), .side_out(ps5_out)
  );

  // T = 2*s13 - s7 as sign and magnitude
  logic              vt;
  logic [WORD_W-1:0] tmag, tmag_next, twice;
  logic              t_huge;
  mag_side_t         ms_in;

  assign twice  = {p5[0][WORD_W-2:0], 1'b0};
  assign t_huge = ps5_out.h7 | ps5_out.h13 | o5[0] | p5[0][WORD_W-1];

  always_comb begin
    ms_in.fl     = ps5_out.fl;
    ms_in.cx     = ps5_out.cx;
    ms_in.cy     = ps5_out.cy;
    ms_in.t_huge = t_huge;
    ms_in.t_neg  = 1'b0;
    tmag_next    = '0;
    if (!t_huge) begin
      if (twice >= ps5_out.s7) begin
        tmag_next = twice - ps5_out.s7;
      end else begin
        tmag_next   = ps5_out.s7 - twice;
        ms_in.t_neg = 1'b1;
      end
    end
  end

  mag_side_t ms_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (advance) begin
      vt <= vm5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tmag <= tmag_next;
      ms_q <= ms_in;
    end
  end

  // M = force_scale * |T|
  logic                   vm6;
  logic [0:0][WORD_W-1:0] p6;
  logic [0:0]             o6;
  mag_side_t              ms_out;

  ljpf_mulq #(.LANES(1), .SIDE_W($bits(mag_side_t))) u_mag (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vt),
    .a({{(WORD_W-SCALE_W){1'b0}}, force_scale}), .b(tmag), .side_in(ms_q),
    .out_valid(vm6), .res(p6), .ovf(o6), .side_out(ms_out)
  );

  // components M * cos
  comp_side_t             cs_in, cs_out;
  logic                   vm7;
  logic [1:0][WORD_W-1:0] m7_a, m7_b, p7;
  logic [1:0]             o7;

  always_comb begin
    cs_in.fl      = ms_out.fl;
    cs_in.t_neg   = ms_out.t_neg;
    cs_in.m_unb   = ms_out.t_huge ? (force_scale != '0) : o6[0];
    cs_in.cx_zero = (ms_out.cx == '0);
    cs_in.cy_zero = (ms_out.cy == '0);
    m7_a[0]       = p6[0];
    m7_a[1]       = p6[0];
    m7_b[0]       = {{(WORD_W-COS_W){1'b0}}, ms_out.cx};
    m7_b[1]       = {{(WORD_W-COS_W){1'b0}}, ms_out.cy};
  end

  ljpf_mulq #(.LANES(2), .SIDE_W($bits(comp_side_t))) u_comp (
    .clk(clk), .rst(rst), .en(advance), .in_valid(vm6),
    .a(m7_a), .b(m7_b), .side_in(cs_in),
    .out_valid(vm7), .res(p7), .ovf(o7), .side_out(cs_out)
  );

  // sign, clipping and special cases
  comp_out_t          fx, fy;
  logic               fin_valid;
  logic [FORCE_W-1:0] fin_x, fin_y;
  logic               fin_sat, fin_coin;

  assign fx = comp_force(p7[0], o7[0], cs_out.m_unb, cs_out.t_neg ^ cs_out.fl.neg_x,
                         cs_out.cx_zero);
  assign fy = comp_force(p7[1], o7[1], cs_out.m_unb, cs_out.t_neg ^ cs_out.fl.neg_y,
                         cs_out.cy_zero);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (advance) begin
      fin_valid <= vm7;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fin_coin <= cs_out.fl.coincident;
      if (cs_out.fl.coincident || cs_out.fl.outside) begin
        fin_x   <= '0;
        fin_y   <= '0;
        fin_sat <= 1'b0;
      end else begin
        fin_x   <= fx.val;
        fin_y   <= fy.val;
        fin_sat <= fx.sat | fy.sat;
      end
    end
  end

  // output register and skid stage
  logic         skid_valid;
  logic [127:0] skid_data;
  logic [1:0]   skid_user;
  logic         out_free;

  assign advance  = !skid_valid;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= fin_valid;
      end
    end else if (fin_valid && advance) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= {fin_y, fin_x};
        m_tuser <= {fin_coin, fin_sat};
      end
    end else if (advance) begin
      skid_data <= {fin_y, fin_x};
      skid_user <= {fin_coin, fin_sat};
    end
  end

`ifndef SYNTHESIS
  // a parked transaction in the skid stage implies the output is occupied
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid stage holds a transaction while the output is empty");

  // a parked transaction is not dropped while the output stays stalled
  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> skid_valid)
    else $error("skid transaction lost during output stall");

  // coincident particles give zero forces and no clipping
  a_coincident_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]))
    else $error("coincident result carries a nonzero force");
`endif

endmodule
